// ===== hw/rtl/torus_cell_vertex_generator_macros.svh =====
// Assertion macros for the torus cell vertex generator.
// Used by files that assert; expects clk and arst_n in scope.
`ifndef TORUS_CELL_VERTEX_GENERATOR_MACROS_SVH
`define TORUS_CELL_VERTEX_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TCVG_CHECK(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcvg check failed");
// next-cycle implication
`define TCVG_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcvg check failed");
`else
`define TCVG_CHECK(lbl, ante, cons)
`define TCVG_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/tcvg_pkg.sv =====
// Shared types and constants of the torus cell vertex generator.
// No dependencies.
`default_nettype none
package tcvg_pkg;

	// field widths
	localparam int IDX_W   = 9;                 // loop / slice index
	localparam int K_W     = IDX_W + 1;         // index plus one
	localparam int CNT_W   = 9;                 // division counts
	localparam int REM_W   = CNT_W;             // divider remainder
	localparam int PH_W    = 32;                // phase, 2^32 per turn
	localparam int DIV_STEPS = K_W + PH_W;      // one quotient bit per cell
	localparam int CORDIC_STEPS = 16;
	localparam int CW      = 33;                // CORDIC datapath
	localparam int TRIG_W  = 17;                // Q.14 trig value
	localparam int RAD_W   = 15;
	localparam int CTR_W   = 8;
	localparam int COORD_W = 20;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W   = 15;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

	localparam logic signed [CW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		33'sh020000000, 33'sh012E4051D, 33'sh009FB385B, 33'sh0051111D4,
		33'sh0028B0D43, 33'sh00145D7E1, 33'sh000A2F61E, 33'sh000517C55,
		33'sh00028BE53, 33'sh000145F2E, 33'sh0000A2F98, 33'sh0000517CC,
		33'sh000028BE6, 33'sh0000145F3, 33'sh00000A2F9, 33'sh00000517C
	};

	// corner sequence a, a1, b, b, a1, b1: bit n is corner n
	localparam logic [5:0] LOOP_NEXT  = 6'b110010;
	localparam logic [5:0] SLICE_NEXT = 6'b101100;
	localparam logic [2:0] CORNER_LAST = 3'd5;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAJOR_RADIUS = 3'd0,
		REG_MINOR_RADIUS = 3'd1,
		REG_SLICE_COUNT  = 3'd2,
		REG_LOOP_COUNT   = 3'd3,
		REG_CENTER_X     = 3'd4,
		REG_CENTER_Y     = 3'd5,
		REG_CENTER_Z     = 3'd6
	} cfg_reg_t;

	localparam logic [RAD_W-1:0] MAJOR_RESET = 15'd1638;
	localparam logic [RAD_W-1:0] MINOR_RESET = 15'd819;
	localparam logic [CNT_W-1:0] COUNT_RESET = 9'd20;

	// control that travels with each vertex down the chain
	typedef struct packed {
		logic       valid;
		logic [2:0] corner;
	} tag_t;

endpackage
`default_nettype wire

// ===== hw/rtl/torus_cell_vertex_generator.sv =====
// Torus cell vertex generator top level: config registers, issue, cell chains.
// Depends on tcvg_pkg, tcvg_div_cell, tcvg_cordic_cell, tcvg_vertex_math.
//
//  channel   dir  handshake            payload
//  s_axis    in   tvalid/tready        tdata: loop_index, slice_index
//  m_axis    out  tvalid/tready/tlast  tdata: vertex_x/y/z, corner; tlast
//  cfg       in   cfg_we               cfg_index, cfg_data
//
// Six vertices per item, one per cycle unless held; items follow without a gap.
// Vertices pass 42 divider cells, 16 CORDIC cells and 5 math stages.
// The whole chain holds when the output register is full and not taken.
// Reset clears valid bits and restores register defaults; no clearing pass.
`default_nettype none
`include "torus_cell_vertex_generator_macros.svh"
module torus_cell_vertex_generator #(
	parameter int MAX_DIVISIONS = 256,
	parameter int FRAC_BITS     = 12
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [23:0] s_axis_tdata,   // [8:0] loop_index, [17:9] slice_index
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [19:0] x, [39:20] y, [59:40] z, [62:60] corner
	output logic        m_axis_tlast,   // last_of_cell
	input  wire         cfg_we,
	input  wire  [tcvg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [tcvg_pkg::CFG_W-1:0]     cfg_data
);
	localparam int DS = tcvg_pkg::DIV_STEPS;
	localparam int CS = tcvg_pkg::CORDIC_STEPS;
	localparam int KW = tcvg_pkg::K_W;
	localparam logic [tcvg_pkg::CNT_W-1:0] NCAP =
		(MAX_DIVISIONS > 511) ? 9'd511 : tcvg_pkg::CNT_W'(MAX_DIVISIONS);

	// configuration registers
	logic [tcvg_pkg::RAD_W-1:0]        major_q, minor_q;
	logic [tcvg_pkg::CNT_W-1:0]        slice_cnt_q, loop_cnt_q;
	logic signed [tcvg_pkg::CTR_W-1:0] cx_q, cy_q, cz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_q     <= tcvg_pkg::MAJOR_RESET;
			minor_q     <= tcvg_pkg::MINOR_RESET;
			slice_cnt_q <= tcvg_pkg::COUNT_RESET;
			loop_cnt_q  <= tcvg_pkg::COUNT_RESET;
			cx_q        <= '0;
			cy_q        <= '0;
			cz_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tcvg_pkg::REG_MAJOR_RADIUS: major_q     <= cfg_data;
				tcvg_pkg::REG_MINOR_RADIUS: minor_q     <= cfg_data;
				tcvg_pkg::REG_SLICE_COUNT:  slice_cnt_q <= cfg_data[tcvg_pkg::CNT_W-1:0];
				tcvg_pkg::REG_LOOP_COUNT:   loop_cnt_q  <= cfg_data[tcvg_pkg::CNT_W-1:0];
				tcvg_pkg::REG_CENTER_X:     cx_q        <= cfg_data[tcvg_pkg::CTR_W-1:0];
				tcvg_pkg::REG_CENTER_Y:     cy_q        <= cfg_data[tcvg_pkg::CTR_W-1:0];
				tcvg_pkg::REG_CENTER_Z:     cz_q        <= cfg_data[tcvg_pkg::CTR_W-1:0];
				default: ;
			endcase
		end
	end

	// effective divisors: zero reads as one, clamp at the cap
	logic [tcvg_pkg::CNT_W-1:0] loop_n, slice_n;
	always_comb begin
		loop_n  = (loop_cnt_q == '0) ? tcvg_pkg::CNT_W'(1)
		        : ((loop_cnt_q > NCAP) ? NCAP : loop_cnt_q);
		slice_n = (slice_cnt_q == '0) ? tcvg_pkg::CNT_W'(1)
		        : ((slice_cnt_q > NCAP) ? NCAP : slice_cnt_q);
	end

	// chain advance: output register empty or being taken
	tcvg_pkg::tag_t out_tag;
	logic en;
	assign en = !out_tag.valid || m_axis_tready;

	// input item register and corner issue counter
	logic                       item_valid_q;
	logic [tcvg_pkg::IDX_W-1:0] loop_q, slice_q;
	logic [2:0]                 corner_q;
	logic                       issue, in_xfer;

	assign issue         = en && item_valid_q;
	assign s_axis_tready = !item_valid_q || (issue && corner_q == tcvg_pkg::CORNER_LAST);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
			corner_q     <= '0;
		end else begin
			if (in_xfer)
				item_valid_q <= 1'b1;
			else if (issue && corner_q == tcvg_pkg::CORNER_LAST)
				item_valid_q <= 1'b0;
			if (issue)
				corner_q <= (corner_q == tcvg_pkg::CORNER_LAST) ? 3'd0 : corner_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			loop_q  <= s_axis_tdata[8:0];
			slice_q <= s_axis_tdata[17:9];
		end
	end

	// divider chain
	tcvg_pkg::tag_t                 dtag [DS+1];
	logic [KW-1:0]                  lk [DS+1], sk [DS+1];
	logic [tcvg_pkg::REM_W-1:0]     lrem [DS+1], srem [DS+1];
	logic [tcvg_pkg::PH_W-1:0]      lq [DS+1], sq [DS+1];

	always_comb begin
		dtag[0].valid  = issue;
		dtag[0].corner = corner_q;
		lk[0]   = {1'b0, loop_q}  + KW'(tcvg_pkg::LOOP_NEXT[corner_q]);
		sk[0]   = {1'b0, slice_q} + KW'(tcvg_pkg::SLICE_NEXT[corner_q]);
		lrem[0] = '0;
		srem[0] = '0;
		lq[0]   = '0;
		sq[0]   = '0;
	end

	for (genvar g = 0; g < DS; g++) begin : g_div
		tcvg_div_cell #(.STEP(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.loop_n(loop_n), .slice_n(slice_n),
			.tag_in(dtag[g]), .lk_in(lk[g]), .sk_in(sk[g]),
			.lrem_in(lrem[g]), .srem_in(srem[g]), .lq_in(lq[g]), .sq_in(sq[g]),
			.tag_q(dtag[g+1]), .lk_q(lk[g+1]), .sk_q(sk[g+1]),
			.lrem_q(lrem[g+1]), .srem_q(srem[g+1]), .lq_q(lq[g+1]), .sq_q(sq[g+1])
		);
	end

	// CORDIC chain
	tcvg_pkg::tag_t                 ctag [CS+1];
	logic [1:0]                     lquad [CS+1], squad [CS+1];
	logic signed [tcvg_pkg::CW-1:0] lx [CS+1], ly [CS+1], lz [CS+1];
	logic signed [tcvg_pkg::CW-1:0] sx [CS+1], sy [CS+1], sz [CS+1];

	always_comb begin
		ctag[0]  = dtag[DS];
		lquad[0] = lq[DS][31:30];
		squad[0] = sq[DS][31:30];
		lx[0]    = tcvg_pkg::CORDIC_GAIN;
		sx[0]    = tcvg_pkg::CORDIC_GAIN;
		ly[0]    = '0;
		sy[0]    = '0;
		lz[0]    = {3'b000, lq[DS][29:0]};
		sz[0]    = {3'b000, sq[DS][29:0]};
	end

	for (genvar g = 0; g < CS; g++) begin : g_cordic
		tcvg_cordic_cell #(.STEP(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.tag_in(ctag[g]), .lquad_in(lquad[g]), .squad_in(squad[g]),
			.lx_in(lx[g]), .ly_in(ly[g]), .lz_in(lz[g]),
			.sx_in(sx[g]), .sy_in(sy[g]), .sz_in(sz[g]),
			.tag_q(ctag[g+1]), .lquad_q(lquad[g+1]), .squad_q(squad[g+1]),
			.lx_q(lx[g+1]), .ly_q(ly[g+1]), .lz_q(lz[g+1]),
			.sx_q(sx[g+1]), .sy_q(sy[g+1]), .sz_q(sz[g+1])
		);
	end

	// vertex arithmetic and output register
	logic signed [tcvg_pkg::COORD_W-1:0] vx, vy, vz;

	tcvg_vertex_math #(.FRAC_BITS(FRAC_BITS)) u_math (
		.clk(clk), .arst_n(arst_n), .en(en),
		.tag_in(ctag[CS]), .lquad(lquad[CS]), .squad(squad[CS]),
		.lx(lx[CS]), .ly(ly[CS]), .sx(sx[CS]), .sy(sy[CS]),
		.major_radius(major_q), .minor_radius(minor_q),
		.center_x(cx_q), .center_y(cy_q), .center_z(cz_q),
		.tag_s5(out_tag), .vx_s5(vx), .vy_s5(vy), .vz_s5(vz)
	);

	assign m_axis_tvalid = out_tag.valid;
	assign m_axis_tlast  = (out_tag.corner == tcvg_pkg::CORNER_LAST);
	assign m_axis_tdata  = {1'b0, out_tag.corner, vz, vy, vx};

	// checks
	`TCVG_CHECK(a_corner_range, 1'b1, corner_q <= tcvg_pkg::CORNER_LAST)
	`TCVG_CHECK_NEXT(a_load_restarts, in_xfer, corner_q == 3'd0 && item_valid_q)
	`TCVG_CHECK(a_out_corner, m_axis_tvalid, out_tag.corner <= tcvg_pkg::CORNER_LAST)
	`TCVG_CHECK_NEXT(a_issue_counts, issue && corner_q != tcvg_pkg::CORNER_LAST,
		item_valid_q && corner_q != 3'd0)

endmodule
`default_nettype wire

// ===== hw/rtl/tcvg_div_cell.sv =====
// One restoring-division cell: one quotient bit of k*2^32/n per lane.
// Depends on tcvg_pkg.
`default_nettype none
module tcvg_div_cell #(
	parameter int STEP = 0
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire [tcvg_pkg::CNT_W-1:0]    loop_n,
	input  wire [tcvg_pkg::CNT_W-1:0]    slice_n,
	input  tcvg_pkg::tag_t               tag_in,
	input  wire [tcvg_pkg::K_W-1:0]      lk_in,
	input  wire [tcvg_pkg::K_W-1:0]      sk_in,
	input  wire [tcvg_pkg::REM_W-1:0]    lrem_in,
	input  wire [tcvg_pkg::REM_W-1:0]    srem_in,
	input  wire [tcvg_pkg::PH_W-1:0]     lq_in,
	input  wire [tcvg_pkg::PH_W-1:0]     sq_in,
	output tcvg_pkg::tag_t               tag_q,
	output logic [tcvg_pkg::K_W-1:0]     lk_q,
	output logic [tcvg_pkg::K_W-1:0]     sk_q,
	output logic [tcvg_pkg::REM_W-1:0]   lrem_q,
	output logic [tcvg_pkg::REM_W-1:0]   srem_q,
	output logic [tcvg_pkg::PH_W-1:0]    lq_q,
	output logic [tcvg_pkg::PH_W-1:0]    sq_q
);
	localparam int BI = (STEP < tcvg_pkg::K_W) ? (tcvg_pkg::K_W - 1 - STEP) : 0;

	logic                       lbit, sbit, lge, sge;
	logic [tcvg_pkg::REM_W:0]   lr2, sr2, lsub, ssub;

	// shift in next dividend bit, compare and subtract
	always_comb begin
		lbit = (STEP < tcvg_pkg::K_W) ? lk_in[BI] : 1'b0;
		sbit = (STEP < tcvg_pkg::K_W) ? sk_in[BI] : 1'b0;
		lr2  = {lrem_in, lbit};
		sr2  = {srem_in, sbit};
		lge  = lr2 >= {1'b0, loop_n};
		sge  = sr2 >= {1'b0, slice_n};
		lsub = lr2 - {1'b0, loop_n};
		ssub = sr2 - {1'b0, slice_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lk_q   <= lk_in;
			sk_q   <= sk_in;
			lrem_q <= lge ? lsub[tcvg_pkg::REM_W-1:0] : lr2[tcvg_pkg::REM_W-1:0];
			srem_q <= sge ? ssub[tcvg_pkg::REM_W-1:0] : sr2[tcvg_pkg::REM_W-1:0];
			lq_q   <= {lq_in[tcvg_pkg::PH_W-2:0], lge};
			sq_q   <= {sq_in[tcvg_pkg::PH_W-2:0], sge};
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/tcvg_cordic_cell.sv =====
// One CORDIC rotation step for the loop and the slice angle.
// Depends on tcvg_pkg.
`default_nettype none
module tcvg_cordic_cell #(
	parameter int STEP = 0
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             en,
	input  tcvg_pkg::tag_t                  tag_in,
	input  wire [1:0]                       lquad_in,
	input  wire [1:0]                       squad_in,
	input  wire signed [tcvg_pkg::CW-1:0]   lx_in, ly_in, lz_in,
	input  wire signed [tcvg_pkg::CW-1:0]   sx_in, sy_in, sz_in,
	output tcvg_pkg::tag_t                  tag_q,
	output logic [1:0]                      lquad_q,
	output logic [1:0]                      squad_q,
	output logic signed [tcvg_pkg::CW-1:0]  lx_q, ly_q, lz_q,
	output logic signed [tcvg_pkg::CW-1:0]  sx_q, sy_q, sz_q
);
	localparam logic signed [tcvg_pkg::CW-1:0] ANG = tcvg_pkg::ATAN_TURNS[STEP];

	logic signed [tcvg_pkg::CW-1:0] ldx, ldy, sdx, sdy;

	always_comb begin
		ldx = ly_in >>> STEP;
		ldy = lx_in >>> STEP;
		sdx = sy_in >>> STEP;
		sdy = sx_in >>> STEP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_in;
		end
	end

	// rotate toward zero residual angle
	always_ff @(posedge clk) begin
		if (en) begin
			lquad_q <= lquad_in;
			squad_q <= squad_in;
			if (!lz_in[tcvg_pkg::CW-1]) begin
				lx_q <= lx_in - ldx;
				ly_q <= ly_in + ldy;
				lz_q <= lz_in - ANG;
			end else begin
				lx_q <= lx_in + ldx;
				ly_q <= ly_in - ldy;
				lz_q <= lz_in + ANG;
			end
			if (!sz_in[tcvg_pkg::CW-1]) begin
				sx_q <= sx_in - sdx;
				sy_q <= sy_in + sdy;
				sz_q <= sz_in - ANG;
			end else begin
				sx_q <= sx_in + sdx;
				sy_q <= sy_in - sdy;
				sz_q <= sz_in + ANG;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/tcvg_vertex_math.sv =====
// Vertex arithmetic: trig rounding, radius products, center and saturation.
// Depends on tcvg_pkg. Last stage is the output register.
`default_nettype none
module tcvg_vertex_math #(
	parameter int FRAC_BITS = 12
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 en,
	input  tcvg_pkg::tag_t                      tag_in,
	input  wire [1:0]                           lquad,
	input  wire [1:0]                           squad,
	input  wire signed [tcvg_pkg::CW-1:0]       lx, ly, sx, sy,
	input  wire [tcvg_pkg::RAD_W-1:0]           major_radius,
	input  wire [tcvg_pkg::RAD_W-1:0]           minor_radius,
	input  wire signed [tcvg_pkg::CTR_W-1:0]    center_x, center_y, center_z,
	output tcvg_pkg::tag_t                      tag_s5,
	output logic signed [tcvg_pkg::COORD_W-1:0] vx_s5, vy_s5, vz_s5
);
	localparam int TW = tcvg_pkg::TRIG_W;
	localparam int PW = 33;   // radius times trig
	localparam int RW = 20;   // rho
	localparam int XW = RW + TW;
	localparam int SW = 32;   // final sum
	localparam logic signed [SW-1:0] CMAX = 32'sd524287;
	localparam logic signed [SW-1:0] CMIN = -32'sd524288;

	tcvg_pkg::tag_t tag_s1, tag_s2, tag_s3, tag_s4;

	logic signed [tcvg_pkg::CW-1:0] lxr, lyr, sxr, syr;
	logic signed [TW-1:0] lc0, ls0, sc0, ss0, lc, ls, sc, ss;
	logic signed [TW-1:0] lc_s1, ls_s1, sc_s1, ss_s1, lc_s2, ls_s2, lc_s3, ls_s3;
	logic signed [PW-1:0] pr_s2, pz_s2, pr_r, pz_r;
	logic signed [RW-1:0] rho_s3, zz_s3, zz_s4;
	logic signed [XW-1:0] px_s4, py_s4, px_r, py_r;
	logic signed [SW-1:0] cx, cy, cz, sumx, sumy, sumz;

	function automatic logic signed [SW-1:0] sat_sum(input logic signed [SW-1:0] v);
		sat_sum = (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
	endfunction

	// round Q1.30 to Q.14 and unfold quadrant
	always_comb begin
		lxr = lx + (tcvg_pkg::CW)'(33'sd32768);
		lyr = ly + (tcvg_pkg::CW)'(33'sd32768);
		sxr = sx + (tcvg_pkg::CW)'(33'sd32768);
		syr = sy + (tcvg_pkg::CW)'(33'sd32768);
		lc0 = lxr[tcvg_pkg::CW-1:16];
		ls0 = lyr[tcvg_pkg::CW-1:16];
		sc0 = sxr[tcvg_pkg::CW-1:16];
		ss0 = syr[tcvg_pkg::CW-1:16];
		case (lquad)
			2'd0:    begin lc = lc0;  ls = ls0;  end
			2'd1:    begin lc = -ls0; ls = lc0;  end
			2'd2:    begin lc = -lc0; ls = -ls0; end
			default: begin lc = ls0;  ls = -lc0; end
		endcase
		case (squad)
			2'd0:    begin sc = sc0;  ss = ss0;  end
			2'd1:    begin sc = -ss0; ss = sc0;  end
			2'd2:    begin sc = -sc0; ss = -ss0; end
			default: begin sc = ss0;  ss = -sc0; end
		endcase
	end

	// rounding of products by 2^14, centers in Q.FRAC_BITS
	always_comb begin
		pr_r = pr_s2 + PW'(33'sd8192);
		pz_r = pz_s2 + PW'(33'sd8192);
		px_r = px_s4 + XW'(37'sd8192);
		py_r = py_s4 + XW'(37'sd8192);
		cx   = SW'(center_x) <<< FRAC_BITS;
		cy   = SW'(center_y) <<< FRAC_BITS;
		cz   = SW'(center_z) <<< FRAC_BITS;
		sumx = SW'($signed(px_r[XW-1:14])) + cx;
		sumy = SW'($signed(py_r[XW-1:14])) + cy;
		sumz = SW'(zz_s4) + cz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: trig values
			lc_s1 <= lc;
			ls_s1 <= ls;
			sc_s1 <= sc;
			ss_s1 <= ss;
			// s2: tube radius products
			pr_s2 <= PW'($signed({1'b0, minor_radius}) * sc_s1);
			pz_s2 <= PW'($signed({1'b0, minor_radius}) * ss_s1);
			lc_s2 <= lc_s1;
			ls_s2 <= ls_s1;
			// s3: ring distance and height
			rho_s3 <= RW'($signed({1'b0, major_radius})) + RW'($signed(pr_r[PW-1:14]));
			zz_s3  <= RW'($signed(pz_r[PW-1:14]));
			lc_s3  <= lc_s2;
			ls_s3  <= ls_s2;
			// s4: ring products
			px_s4 <= XW'(rho_s3 * lc_s3);
			py_s4 <= XW'(rho_s3 * ls_s3);
			zz_s4 <= zz_s3;
			// s5: center, saturate, output register
			vx_s5 <= tcvg_pkg::COORD_W'(sat_sum(sumx));
			vy_s5 <= tcvg_pkg::COORD_W'(sat_sum(sumy));
			vz_s5 <= tcvg_pkg::COORD_W'(sat_sum(sumz));
		end
	end
endmodule
`default_nettype wire
